// ===== sv/online_pair_covariance_macros.svh =====
// Assertion macros for the online pair covariance block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ONLINE_PAIR_COVARIANCE_MACROS_SVH
`define ONLINE_PAIR_COVARIANCE_MACROS_SVH

// same-cycle implication
`define OPC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/opc_pkg.sv =====
// Package for the online pair covariance block: payload structs, operation codes,
// controller command and status structs, shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package opc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int MEAN_GUARD       = 16;
    localparam int FRAC_BITS        = 16;

    typedef struct packed {
        logic        start_req;
        logic [31:0] sample_x;
        logic [31:0] sample_y;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] covariance;
        logic        [31:0] pair_count;
        logic               estimate_valid;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_DX,
        OP_DY,
        OP_MA,
        OP_MB,
        OP_DC,
        OP_MP,
        OP_DP
    } op_t;

    typedef struct packed {
        logic load;
        logic go;
        logic commit;
        logic out_load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic n_lt2;
    } status_t;

    function automatic logic is_div_op(op_t op);
        return (op == OP_DX) || (op == OP_DY) || (op == OP_DC) || (op == OP_DP);
    endfunction

endpackage
`default_nettype wire

// ===== sv/opc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Used by opc_datapath; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module opc_div #(
    parameter int DW = 96,
    parameter int VW = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic      [DW-1:0] quotient,
    output logic               done
);
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VW-1:0]    rem_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    dvs_reg;
    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             ge;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[DW-2:0], ge};
                rem_reg <= ge ? diff[VW-1:0] : trial[VW-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/opc_mul.sv =====
// Iterative shift-add multiplier, one multiplier bit per cycle.
// Used by opc_datapath; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module opc_mul #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [AW-1:0]    op_a,
    input  wire logic [BW-1:0]    op_b,
    output logic      [AW+BW-1:0] product,
    output logic                  done
);
    localparam int CNT_W = $clog2(BW + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [AW+BW-1:0]   acc_reg;
    logic [AW+BW-1:0]   a_sh_reg;
    logic [BW-1:0]      b_sh_reg;

    assign product = acc_reg;
    assign done    = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(BW);
                acc_reg  <= '0;
                a_sh_reg <= (AW+BW)'(op_a);
                b_sh_reg <= op_b;
            end else if (busy_reg) begin
                if (b_sh_reg[0]) begin
                    acc_reg <= acc_reg + a_sh_reg;
                end
                a_sh_reg <= {a_sh_reg[AW+BW-2:0], 1'b0};
                b_sh_reg <= {1'b0, b_sh_reg[BW-1:1]};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/opc_datapath.sv =====
// Datapath: running state, operand selection, shared divider and multiplier,
// result register. Depends on opc_pkg, opc_div, opc_mul.
`timescale 1ns / 1ps
`default_nettype none
module opc_datapath #(
    parameter int SAMPLE_WIDTH = opc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = opc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire opc_pkg::in_item_t  s_item,
    input  wire opc_pkg::cmd_t      cmd,
    output opc_pkg::status_t        status,
    output opc_pkg::out_item_t      m_item
);
    import opc_pkg::*;

    localparam int MW    = SAMPLE_WIDTH + MEAN_GUARD;
    localparam int DIV_W = 64 + COUNT_WIDTH;
    localparam int SH    = 2 * MEAN_GUARD;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    logic [COUNT_WIDTH-1:0] n_reg;
    logic signed [MW-1:0]   mean_x_reg, mean_y_reg;
    logic signed [63:0]     com_reg;
    logic signed [MW-1:0]   x_reg, y_reg;
    logic [MW:0]            d1_mag_reg, d2_mag_reg;
    logic                   d1_neg_reg, d2_neg_reg;
    logic [63:0]            a_reg;
    logic signed [63:0]     term_reg;
    logic [DIV_W-1:0]       p_reg;
    logic signed [63:0]     cov_reg;
    out_item_t              m_item_reg;

    logic [COUNT_WIDTH-1:0] n_base;
    logic signed [MW:0]     diff_x, diff_y, diff_sel;
    logic [MW:0]            diff_mag;
    logic [63:0]            com_mag;
    logic [DIV_W-1:0]       div_dividend;
    logic [COUNT_WIDTH-1:0] div_divisor;
    logic [DIV_W-1:0]       div_q;
    logic                   div_done;
    logic [63:0]            mul_a, mul_b;
    logic [127:0]           mul_p;
    logic                   mul_done;
    logic [MW:0]            qd;
    logic signed [MW:0]     d_signed;
    logic                   d_neg;
    logic [63:0]            t_mag;
    logic signed [63:0]     t_val;
    logic [63:0]            q64, qs;
    logic signed [63:0]     base;
    logic signed [64:0]     sum;
    logic signed [63:0]     com_new;
    logic                   big;
    logic signed [63:0]     cov_val;

    assign n_base   = s_item.start_req ? '0 : n_reg;
    assign diff_x   = {x_reg[MW-1], x_reg} - {mean_x_reg[MW-1], mean_x_reg};
    assign diff_y   = {y_reg[MW-1], y_reg} - {mean_y_reg[MW-1], mean_y_reg};
    assign diff_sel = (cmd.op == OP_DY) ? diff_y : diff_x;
    assign diff_mag = diff_sel[MW] ? (MW+1)'(-diff_sel) : diff_sel;
    assign com_mag  = com_reg[63] ? 64'(-com_reg) : com_reg;

    always_comb begin
        div_dividend = '0;
        div_divisor  = n_reg;
        mul_a        = '0;
        mul_b        = '0;
        case (cmd.op)
            OP_DX, OP_DY: div_dividend = DIV_W'(diff_mag);
            OP_DC:        div_dividend = DIV_W'(com_mag);
            OP_DP: begin
                div_dividend = p_reg;
                div_divisor  = n_reg - 1'b1;
            end
            OP_MA: begin
                mul_a = 64'(n_reg - 1'b1);
                mul_b = 64'(d1_mag_reg);
            end
            OP_MB: begin
                mul_a = a_reg;
                mul_b = 64'(d2_mag_reg);
            end
            OP_MP: begin
                mul_a = com_mag;
                mul_b = 64'(n_reg);
            end
            default: ;
        endcase
    end

    opc_div #(.DW(DIV_W), .VW(COUNT_WIDTH)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.go && is_div_op(cmd.op)),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    opc_mul #(.AW(64), .BW(64)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.go && !is_div_op(cmd.op)),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p),
        .done    (mul_done)
    );

    // mean step: signed truncating quotient
    assign qd       = div_q[MW:0];
    assign d_signed = diff_sel[MW] ? (MW+1)'(-qd) : qd;
    assign d_neg    = diff_sel[MW] && (qd != '0);

    // co-moment product term
    always_comb begin
        if ((|mul_p[127:64+SH]) || mul_p[63+SH]) begin
            t_mag = 64'(S64_MAX);
        end else begin
            t_mag = mul_p[63+SH:SH];
        end
    end
    assign t_val = (d1_neg_reg != d2_neg_reg) ? 64'(-t_mag) : t_mag;

    // co-moment decay and saturating add
    assign q64     = div_q[63:0];
    assign qs      = com_reg[63] ? 64'(-q64) : q64;
    assign base    = com_reg - qs;
    assign sum     = {base[63], base} + {term_reg[63], term_reg};
    assign com_new = (sum[64] != sum[63]) ? (sum[64] ? S64_MIN : S64_MAX) : sum[63:0];

    // final scale by n/(n-1)
    assign big     = |div_q[DIV_W-1:63];
    assign cov_val = big ? (com_reg[63] ? S64_MIN : S64_MAX)
                         : (com_reg[63] ? 64'(-q64) : q64);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg      <= '0;
            mean_x_reg <= '0;
            mean_y_reg <= '0;
            com_reg    <= '0;
        end else if (cmd.load) begin
            n_reg <= (n_base == COUNT_MAX) ? COUNT_MAX : n_base + 1'b1;
            if (s_item.start_req) begin
                mean_x_reg <= '0;
                mean_y_reg <= '0;
                com_reg    <= '0;
            end
        end else if (cmd.commit) begin
            case (cmd.op)
                OP_DX:   mean_x_reg <= MW'(mean_x_reg + d_signed[MW-1:0]);
                OP_DY:   mean_y_reg <= MW'(mean_y_reg + d_signed[MW-1:0]);
                OP_DC:   com_reg    <= com_new;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= {$signed(s_item.sample_x[SAMPLE_WIDTH-1:0]), {MEAN_GUARD{1'b0}}};
            y_reg <= {$signed(s_item.sample_y[SAMPLE_WIDTH-1:0]), {MEAN_GUARD{1'b0}}};
        end
        if (cmd.commit) begin
            case (cmd.op)
                OP_DX: begin
                    d1_mag_reg <= qd;
                    d1_neg_reg <= d_neg;
                end
                OP_DY: begin
                    d2_mag_reg <= qd;
                    d2_neg_reg <= d_neg;
                end
                OP_MA:   a_reg    <= mul_p[63:0];
                OP_MB:   term_reg <= t_val;
                OP_MP:   p_reg    <= mul_p[DIV_W-1:0];
                OP_DP:   cov_reg  <= cov_val;
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            m_item_reg.covariance     <= status.n_lt2 ? 64'sd0 : cov_reg;
            m_item_reg.pair_count     <= 32'(n_reg);
            m_item_reg.estimate_valid <= !status.n_lt2;
        end
    end

    assign status.done  = div_done || mul_done;
    assign status.n_lt2 = n_reg < COUNT_WIDTH'(2);
    assign m_item       = m_item_reg;
endmodule
`default_nettype wire

// ===== sv/opc_ctrl.sv =====
// Controller: sequences the divide and multiply steps of one pair and runs
// both handshakes. Depends on opc_pkg and online_pair_covariance_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "online_pair_covariance_macros.svh"
module opc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output opc_pkg::cmd_t         cmd,
    input  wire opc_pkg::status_t status
);
    import opc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_GO, S_WAIT, S_OUT} state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '{load: 1'b0, go: 1'b0, commit: 1'b0, out_load: 1'b0, op: op_reg};
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    op_next    = OP_DX;
                    state_next = S_GO;
                end
            end
            S_GO: begin
                cmd.go     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (status.done) begin
                    cmd.commit = 1'b1;
                    state_next = S_GO;
                    case (op_reg)
                        OP_DX: op_next = OP_DY;
                        OP_DY: op_next = OP_MA;
                        OP_MA: op_next = OP_MB;
                        OP_MB: op_next = OP_DC;
                        OP_DC: begin
                            op_next = OP_MP;
                            if (status.n_lt2) begin
                                state_next = S_OUT;
                            end
                        end
                        OP_MP: op_next = OP_DP;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_DX;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `OPC_ASSERT_IMPL(a_commit_done, aclk, aresetn, cmd.commit, status.done, "commit without unit done")
    `OPC_ASSERT_NEXT(a_accept_go, aclk, aresetn, s_valid && s_ready, state_reg == S_GO, "accept did not start sequence")
    `OPC_ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.out_load, m_valid_reg, "result load without valid")
    `OPC_ASSERT_NEXT(a_go_not_done, aclk, aresetn, cmd.go, !status.done, "unit done right after start")
endmodule
`default_nettype wire

// ===== sv/online_pair_covariance.sv =====
// Running unbiased covariance of (x, y) sample pairs, Welford-style, fixed point.
// Input channel s_*: one pair per transfer (start_req, sample_x, sample_y, Q16.16).
// start_req clears count, means and co-moment before the pair is taken in.
// Output channel m_*: one transfer per pair (covariance Q32.32, pair_count,
// estimate_valid); covariance is 0 until two pairs are in the series.
// Each pair runs four divisions through one bit-serial divider and three
// products through one bit-serial multiplier; when the count is below two,
// the last product and the last division are skipped.
// The input is accepted again as soon as the result sits in the output
// register; a stalled receiver holds m_valid and the payload and delays the
// next result's load, and with it the acceptance of the pair after that.
// Reset (aresetn low, synchronous) clears count, means and co-moment and
// drops m_valid; the first pair after reset starts a series.
// Depends on opc_pkg, opc_ctrl, opc_datapath.
`timescale 1ns / 1ps
`default_nettype none
module online_pair_covariance #(
    parameter int SAMPLE_WIDTH = opc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = opc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire opc_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output opc_pkg::out_item_t      m_item
);
    import opc_pkg::*;

    cmd_t    cmd;
    status_t status;

    opc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    opc_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_item  (m_item)
    );
endmodule
`default_nettype wire

// ===== bench/opc_checker.sv =====
// Covariance checker: watches both channels, predicts each result from the
// accepted pairs and compares field by field. Depends on opc_pkg.
`timescale 1ns / 1ps
module opc_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire opc_pkg::in_item_t  s_item,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire opc_pkg::out_item_t m_item,
    output int                      fail_count,
    output int                      pending
);
    import opc_pkg::*;

    localparam logic [63:0] POS_MAX = 64'h7fffffffffffffff;
    localparam logic [63:0] NEG_MIN = 64'h8000000000000000;

    logic [31:0]        cnt;
    logic signed [63:0] mx, my, cm;
    out_item_t          want_q[$];

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic signed [63:0] sat_signed(logic [127:0] m, logic neg);
        if (neg) return (m >= 128'(NEG_MIN)) ? NEG_MIN : -m[63:0];
        return (m > 128'(POS_MAX)) ? POS_MAX : m[63:0];
    endfunction

    task automatic predict_pair(in_item_t it);
        logic signed [63:0] x, y, d1, d2, term, base, n_s;
        logic [63:0]  n;
        logic [127:0] prod, q;
        logic signed [64:0] sum;
        logic neg;
        out_item_t r;
        if (it.start_req) begin
            cnt = 0; mx = 0; my = 0; cm = 0;
        end
        x = 64'(signed'(it.sample_x)) <<< MEAN_GUARD;
        y = 64'(signed'(it.sample_y)) <<< MEAN_GUARD;
        if (cnt != 32'hffffffff) cnt = cnt + 1;
        n = 64'(cnt);
        n_s = n;
        d1 = (x - mx) / n_s;
        mx = mx + d1;
        d2 = (y - my) / n_s;
        my = my + d2;
        prod = 128'((n - 1) * mag64(d1)) * 128'(mag64(d2));
        neg = d1[63] != d2[63];
        prod = prod >> (2 * MEAN_GUARD);
        if (prod > 128'(POS_MAX)) prod = 128'(POS_MAX);
        term = neg ? -prod[63:0] : prod[63:0];
        base = cm - cm / n_s;
        sum = 65'(base) + 65'(term);
        if (sum > 65'(signed'(POS_MAX))) cm = POS_MAX;
        else if (sum < -65'sh8000000000000000) cm = NEG_MIN;
        else cm = sum[63:0];
        r.pair_count = cnt;
        if (n < 2) begin
            r.covariance = 0;
            r.estimate_valid = 1'b0;
        end else begin
            q = (128'(mag64(cm)) * 128'(n)) / 128'(n - 1);
            r.covariance = sat_signed(q, cm[63]);
            r.estimate_valid = 1'b1;
        end
        want_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        out_item_t w;
        int errs;
        errs = 0;
        if (!aresetn) begin
            cnt = 0; mx = 0; my = 0; cm = 0;
            fail_count <= 0;
            pending <= 0;
            want_q.delete();
        end else begin
            if (s_valid && s_ready) predict_pair(s_item);
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errs++;
                end else begin
                    w = want_q.pop_front();
                    if (m_item.covariance !== w.covariance) begin
                        $error("covariance: expected %0d, got %0d", w.covariance,
                               m_item.covariance);
                        errs++;
                    end
                    if (m_item.pair_count !== w.pair_count) begin
                        $error("pair_count: expected %0d, got %0d", w.pair_count,
                               m_item.pair_count);
                        errs++;
                    end
                    if (m_item.estimate_valid !== w.estimate_valid) begin
                        $error("estimate_valid: expected %0b, got %0b",
                               w.estimate_valid, m_item.estimate_valid);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= want_q.size();
        end
    end
endmodule

// ===== bench/tb_online_pair_covariance.sv =====
// Testbench top: drives sample pairs with random gaps and output stalls,
// judges the run from the checker's failure count. Depends on opc_pkg, opc_checker.
`timescale 1ns / 1ps
module tb_online_pair_covariance;
    import opc_pkg::*;

    localparam int N_RANDOM   = 700;
    localparam int IDLE_LIMIT = 20000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    int        pairs_sent;
    int        series_started;
    logic      stall_mode;

    online_pair_covariance i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    opc_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("online_pair_covariance verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall before each result while stall_mode is on, quiet stretches included
    initial begin
        int k;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            k = stall_mode ? $urandom_range(0, 7) : 0;
            if (k > 0) begin
                m_ready <= 1'b0;
                repeat (k) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    task automatic send_pair(logic st, logic [31:0] x, logic [31:0] y);
        int gap;
        gap = stall_mode ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= '{start_req: st, sample_x: x, sample_y: y};
        s_valid <= 1'b1;
        @(posedge aclk iff s_ready);
        pairs_sent++;
        if (st) series_started++;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
        endcase
    endfunction

    initial begin
        int left;
        int len;
        s_valid = 1'b0;
        s_item = '0;
        aresetn = 1'b0;
        idle_cycles = 0;
        pairs_sent = 0;
        series_started = 0;
        stall_mode = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no start on first pair, then extremes of the sample range
        send_pair(1'b0, 32'h00010000, 32'h00020000);
        send_pair(1'b0, 32'h00030000, 32'hffff0000);
        send_pair(1'b1, 32'h7fffffff, 32'h7fffffff);
        send_pair(1'b0, 32'h80000000, 32'h80000000);
        send_pair(1'b0, 32'h7fffffff, 32'h7fffffff);
        send_pair(1'b0, 32'h80000000, 32'h80000000);
        send_pair(1'b1, 32'h7fffffff, 32'h80000000);
        send_pair(1'b0, 32'h80000000, 32'h7fffffff);
        send_pair(1'b0, 32'h7fffffff, 32'h80000000);
        send_pair(1'b1, 32'h00000000, 32'h00000000);
        send_pair(1'b0, 32'h00000001, 32'hffffffff);
        send_pair(1'b0, 32'hffffffff, 32'h00000001);
        send_pair(1'b1, 32'h55555555, 32'haaaaaaaa);
        send_pair(1'b0, 32'haaaaaaaa, 32'h55555555);
        send_pair(1'b1, 32'h12345678, 32'h12345678);

        // random series of random length with stalls on and off
        left = N_RANDOM;
        while (left > 0) begin
            stall_mode = $urandom_range(0, 3) != 0;
            len = $urandom_range(1, 40);
            for (int i = 0; i < len && left > 0; i++) begin
                send_pair(i == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0),
                          rand_sample(), rand_sample());
                left--;
            end
        end
        s_valid <= 1'b0;

        wait (pending == 0);
        repeat (1000) @(posedge aclk);
        $display("sent %0d pairs in %0d started series, random gaps and stalls on both sides",
                 pairs_sent, series_started);
        if (fail_count == 0 && pending == 0) begin
            $display("online_pair_covariance verification clean");
        end else begin
            $display("online_pair_covariance verification failed");
        end
        $finish;
    end
endmodule
